>>> hw/rtl/shfd_pkg.sv
// Shared types and constants of the sync-header frame deframer.
// No dependencies; imported by the controller, datapath, top level and checker.
`default_nettype none

package shfd_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int WINDOW_BYTES = HEADER_BYTES - 2;
   localparam int POS_W        = 5;
   localparam int IDX_W        = 4;

   // header byte offsets of the multi-byte fields
   localparam int OFS_SEQ   = 6;
   localparam int OFS_STAMP = 10;
   localparam int OFS_LEN   = 14;

   localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC2    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST_HDR = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_BYTES);

   localparam logic [IDX_W-1:0] REPLAY_LAST  = IDX_W'(WINDOW_BYTES - 1);

   localparam int RSP_DATA_W = 120;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_VERSION     = 2'd2,
      CSR_MAX_PAYLOAD = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_DISCARD = 2'd2
   } kind_type;

   typedef enum logic {
      ST_RUN,
      ST_REPLAY
   } state_type;

   typedef struct packed {
      logic feed_en;     // push one byte through the hunter this cycle
      logic use_replay;  // byte comes from the stored header window
   } cmd_type;

   typedef struct packed {
      logic can_step;    // result slot free or draining this cycle
      logic reject;      // current input byte completes a header with bad length
      logic replay_done; // replay pointer at last stored byte
   } status_type;

endpackage : shfd_pkg

`default_nettype wire

>>> hw/rtl/shfd_ctrl.sv
// Controller of the sync-header frame deframer: run / replay sequencing.
// Depends on shfd_pkg.
`default_nettype none

module shfd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire shfd_pkg::status_type status,
   output shfd_pkg::cmd_type       cmd
);
   import shfd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.feed_en    = 1'b0;
      cmd.use_replay = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready  = status.can_step;
            cmd.feed_en = req_tvalid && status.can_step;
            if (cmd.feed_en && status.reject) begin
               state_in = ST_REPLAY;
            end
         end
         ST_REPLAY: begin
            cmd.use_replay = 1'b1;
            cmd.feed_en    = status.can_step;
            if (status.can_step && status.replay_done) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule : shfd_ctrl

`default_nettype wire

>>> hw/rtl/shfd_dpath.sv
// Datapath of the sync-header frame deframer: config registers, header window,
// hunter state, held header fields and the result register. Depends on shfd_pkg.
`default_nettype none

module shfd_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [shfd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [shfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [7:0]                       req_tdata,
   input  wire shfd_pkg::cmd_type                cmd,
   output shfd_pkg::status_type                  status,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [shfd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);
   import shfd_pkg::*;

   // config
   logic [7:0]  sync_first_ff, sync_second_ff, version_ff;
   logic [15:0] max_payload_ff;

   // hunter state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      remain_ff, remain_in;
   logic [15:0]      hunt_cnt_ff, hunt_cnt_in;
   logic [IDX_W-1:0] replay_idx_ff, replay_idx_in;
   logic [7:0]       held_type_ff, held_type_in;
   logic [7:0]       held_flags_ff, held_flags_in;
   logic [31:0]      held_seq_ff, held_seq_in;
   logic [31:0]      held_stamp_ff, held_stamp_in;
   logic [15:0]      held_len_ff, held_len_in;

   // header bytes 2..15, written in order, no reset
   logic [7:0]       window_ff [WINDOW_BYTES];
   logic             win_we;
   logic [IDX_W-1:0] win_idx;
   logic [POS_W-1:0] win_off;

   // result register
   logic             out_valid_ff, out_valid_in;
   kind_type         out_kind_ff;
   logic [7:0]       out_type_ff, out_flags_ff, out_pay_ff;
   logic [31:0]      out_seq_ff, out_stamp_ff;
   logic [15:0]      out_len_ff, out_drop_ff;
   logic             out_last_ff;

   // emission of this step
   logic             emit;
   kind_type         e_kind;
   logic [7:0]       e_pay;
   logic [15:0]      e_drop;
   logic             e_last;

   logic [7:0]       fb;
   logic [15:0]      len_new;
   logic [15:0]      remain_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'd165;
         sync_second_ff <= 8'd90;
         version_ff     <= 8'd1;
         max_payload_ff <= 16'd1024;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            CSR_VERSION:     version_ff     <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fb         = cmd.use_replay ? window_ff[replay_idx_ff] : req_tdata;
   assign len_new    = {fb, window_ff[OFS_LEN - 2]};
   assign remain_dec = (remain_ff != 16'd0) ? remain_ff - 16'd1 : 16'd0;
   assign win_off    = pos_ff - POS_VERSION;
   assign win_idx    = win_off[IDX_W-1:0];

   always_comb begin
      pos_in        = pos_ff;
      remain_in     = remain_ff;
      hunt_cnt_in   = hunt_cnt_ff;
      held_type_in  = held_type_ff;
      held_flags_in = held_flags_ff;
      held_seq_in   = held_seq_ff;
      held_stamp_in = held_stamp_ff;
      held_len_in   = held_len_ff;
      win_we        = 1'b0;
      emit          = 1'b0;
      e_kind        = KIND_DISCARD;
      e_pay         = 8'd0;
      e_drop        = 16'd0;
      e_last        = 1'b0;

      if (cmd.feed_en) begin
         priority if (pos_ff == POS_PAYLOAD) begin
            remain_in = remain_dec;
            emit      = 1'b1;
            e_kind    = KIND_PAYLOAD;
            e_pay     = fb;
            e_last    = (remain_dec == 16'd0);
            if (remain_dec == 16'd0) begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_LAST_HDR) begin
            win_we = 1'b1;
            if (len_new > max_payload_ff) begin
               emit   = 1'b1;
               e_drop = 16'd2;
               pos_in = POS_HUNT;
            end else begin
               held_type_in  = window_ff[1];
               held_flags_in = window_ff[2];
               held_seq_in   = {window_ff[OFS_SEQ+1], window_ff[OFS_SEQ],
                                window_ff[OFS_SEQ-1], window_ff[OFS_SEQ-2]};
               held_stamp_in = {window_ff[OFS_STAMP+1], window_ff[OFS_STAMP],
                                window_ff[OFS_STAMP-1], window_ff[OFS_STAMP-2]};
               held_len_in   = len_new;
               if (len_new == 16'd0) begin
                  emit   = 1'b1;
                  e_kind = KIND_EMPTY;
                  e_last = 1'b1;
                  pos_in = POS_HUNT;
               end else begin
                  remain_in = len_new;
                  pos_in    = POS_PAYLOAD;
               end
            end
         end else if (pos_ff > POS_VERSION) begin
            win_we = 1'b1;
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == POS_VERSION && fb == version_ff) begin
            win_we = 1'b1;
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == POS_SYNC2 && fb == sync_second_ff) begin
            pos_in = POS_VERSION;
         end else begin
            // hunting, or a failed sync/version check that rehunts this byte;
            // the failed-check cases report the one or two bytes already matched as discarded
            if (pos_ff == POS_SYNC2) begin
               emit   = 1'b1;
               e_drop = 16'd1;
            end else if (pos_ff == POS_VERSION) begin
               emit   = 1'b1;
               e_drop = 16'd2;
            end
            if (fb == sync_first_ff) begin
               if (hunt_cnt_ff != 16'd0) begin
                  emit   = 1'b1;
                  e_drop = hunt_cnt_ff;
               end
               hunt_cnt_in = 16'd0;
               pos_in      = POS_SYNC2;
            end else begin
               if (hunt_cnt_ff != 16'hFFFF) begin
                  hunt_cnt_in = hunt_cnt_ff + 16'd1;
               end
               pos_in = POS_HUNT;
            end
         end
      end
   end

   always_comb begin
      replay_idx_in = replay_idx_ff;
      if (cmd.feed_en && cmd.use_replay) begin
         replay_idx_in = (replay_idx_ff == REPLAY_LAST) ? '0 : replay_idx_ff + IDX_W'(1);
      end
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_HUNT;
         remain_ff     <= '0;
         hunt_cnt_ff   <= '0;
         replay_idx_ff <= '0;
         held_type_ff  <= '0;
         held_flags_ff <= '0;
         held_seq_ff   <= '0;
         held_stamp_ff <= '0;
         held_len_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         remain_ff     <= remain_in;
         hunt_cnt_ff   <= hunt_cnt_in;
         replay_idx_ff <= replay_idx_in;
         held_type_ff  <= held_type_in;
         held_flags_ff <= held_flags_in;
         held_seq_ff   <= held_seq_in;
         held_stamp_ff <= held_stamp_in;
         held_len_ff   <= held_len_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         window_ff[win_idx] <= fb;
      end
   end

   // result payload; header fields are zero on discard reports
   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff  <= e_kind;
         out_type_ff  <= (e_kind != KIND_DISCARD) ? held_type_in  : 8'd0;
         out_flags_ff <= (e_kind != KIND_DISCARD) ? held_flags_in : 8'd0;
         out_seq_ff   <= (e_kind != KIND_DISCARD) ? held_seq_in   : 32'd0;
         out_stamp_ff <= (e_kind != KIND_DISCARD) ? held_stamp_in : 32'd0;
         out_len_ff   <= (e_kind != KIND_DISCARD) ? held_len_in   : 16'd0;
         out_pay_ff   <= e_pay;
         out_drop_ff  <= e_drop;
         out_last_ff  <= e_last;
      end
   end

   assign status.can_step    = !out_valid_ff || rsp_tready;
   assign status.reject      = (pos_ff == POS_LAST_HDR) && (len_new > max_payload_ff);
   assign status.replay_done = (replay_idx_ff == REPLAY_LAST);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_drop_ff, out_pay_ff, out_len_ff, out_stamp_ff, out_seq_ff,
                        out_flags_ff, out_type_ff};

endmodule : shfd_dpath

`default_nettype wire

>>> hw/rtl/sync_header_frame_deframer.sv
// Channel  | Dir | Signals                          | Content
// req      | in  | req_tvalid/tready/tdata[7:0]      | one received stream byte per beat
// rsp      | out | rsp_tvalid/tready/tdata/tuser/tlast | one result per beat
// csr      | in  | csr_we/addr[1:0]/wdata[15:0]      | register write, no handshake
//
// One byte per cycle while the result slot drains; every byte makes at most one result.
// A rejected length replays the 14 stored header bytes at one per cycle while the result
// slot drains; req_tready stays low during the replay.
// The result register is the only buffer: req_tready falls when a result is held and
// rsp_tready is low. Reset is synchronous; all but the window and result data reset.
// Depends on shfd_pkg, shfd_ctrl, shfd_dpath.
`default_nettype none

module sync_header_frame_deframer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // config
   input  wire logic                             csr_we,
   input  wire logic [shfd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [shfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // byte stream in
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // data_byte
   // results out
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // frame_type[7:0], frame_flags[15:8], sequence_number[47:16],
   // time_stamp[79:48], payload_length[95:80], payload_value[103:96],
   // drop_count[119:104]
   output logic [shfd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                            rsp_tuser,  // result_kind
   output logic                                  rsp_tlast   // last_of_frame
);
   import shfd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: normal byte intake vs. header replay after a length reject
   shfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hunter, header capture, payload tagging and result register
   shfd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : sync_header_frame_deframer

`default_nettype wire

>>> hw/rtl/shfd_checker.sv
// Port-level checks for the sync-header frame deframer, bound to the top level.
// Depends on shfd_pkg and sync_header_frame_deframer.
`default_nettype none

module shfd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [shfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [1:0]                       rsp_tuser,
   input wire logic                             rsp_tlast
);
   import shfd_pkg::*;

   // discard reports never close a frame and never carry a zero count
   a_discard_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DISCARD |-> !rsp_tlast && rsp_tdata[119:104] != 16'd0)
      else $error("discard beat malformed");

   // an empty frame closes itself and carries a zero length
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EMPTY |-> rsp_tlast && rsp_tdata[95:80] == 16'd0)
      else $error("empty-frame beat malformed");

   // payload beats belong to a frame with nonzero length
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |-> rsp_tdata[95:80] != 16'd0)
      else $error("payload beat with zero length");

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

endmodule : shfd_checker

bind sync_header_frame_deframer shfd_checker u_shfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
